@@ sv/lbc_pkg.sv @@
// Shared widths, types and helper functions for the line segment clipper.
package lbc_pkg;

  localparam int CW       = 16;  // input coordinate width
  localparam int DW       = 17;  // segment delta and fraction denominator width
  localparam int QW       = 18;  // edge distance and fraction numerator width
  localparam int PW       = 35;  // cross product width
  localparam int NW       = 38;  // rounding dividend width
  localparam int OW       = 12;  // output coordinate width
  localparam int RW       = 13;  // raster size register width
  localparam int QB       = OW;  // quotient bits resolved by the divider
  localparam int LANES    = 4;   // clipped coordinates per segment
  localparam int MAX_DIM  = 4096;
  localparam int RESET_DIM = 1024;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    EDGE_LEFT,
    EDGE_RIGHT,
    EDGE_TOP,
    EDGE_BOTTOM
  } edge_e;

  // Segment data and the running entry and exit fractions t0 = n0/d0, t1 = n1/d1.
  typedef struct packed {
    logic                 ok;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [OW-1:0]        xmax;
    logic [OW-1:0]        ymax;
    logic signed [QW-1:0] n0;
    logic signed [DW-1:0] d0;
    logic signed [QW-1:0] n1;
    logic signed [DW-1:0] d1;
  } clip_st_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } lane_sb_t;

  function automatic logic signed [DW-1:0] edge_p(clip_st_t st, edge_e e);
    logic signed [DW-1:0] p;
    unique case (e)
      EDGE_LEFT:   p = -st.dx;
      EDGE_RIGHT:  p = st.dx;
      EDGE_TOP:    p = -st.dy;
      EDGE_BOTTOM: p = st.dy;
      default:     p = st.dy;
    endcase
    return p;
  endfunction

  function automatic logic signed [QW-1:0] edge_q(clip_st_t st, edge_e e);
    logic signed [QW-1:0] q;
    unique case (e)
      EDGE_LEFT:   q = QW'(st.ax);
      EDGE_RIGHT:  q = $signed(QW'(st.xmax)) - QW'(st.ax);
      EDGE_TOP:    q = QW'(st.ay);
      EDGE_BOTTOM: q = $signed(QW'(st.ymax)) - QW'(st.ay);
      default:     q = QW'(st.ay);
    endcase
    return q;
  endfunction

endpackage

@@ sv/lbc_edge.sv @@
// One edge test of the clipper: cross products, then compare and narrow.
module lbc_edge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  lbc_pkg::clip_st_t               st_i,
  input  logic signed [lbc_pkg::DW-1:0]   p_i,
  input  logic signed [lbc_pkg::QW-1:0]   q_i,
  output logic                            valid_o,
  output lbc_pkg::clip_st_t               st_o
);
  import lbc_pkg::*;

  logic                 pneg, pz, qneg;
  logic signed [QW-1:0] rn;
  logic signed [DW-1:0] rd;
  logic signed [PW-1:0] ma, mb, mc, md;

  logic                 vlda_q;
  clip_st_t             sta_q;
  logic                 pneg_q, pz_q, qneg_q;
  logic signed [QW-1:0] rn_q;
  logic signed [DW-1:0] rd_q;
  logic signed [PW-1:0] ma_q, mb_q, mc_q, md_q;

  clip_st_t             stb_d, stb_q;
  logic                 vldb_q;

  always_comb begin
    pneg = p_i[DW-1];
    pz   = (p_i == '0);
    qneg = q_i[QW-1];
    rn   = pneg ? -q_i : q_i;
    rd   = pneg ? -p_i : p_i;
    ma   = rn * st_i.d1;
    mb   = st_i.n1 * rd;
    mc   = rn * st_i.d0;
    md   = st_i.n0 * rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlda_q <= 1'b0;
    end else if (en_i) begin
      vlda_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sta_q  <= st_i;
      pneg_q <= pneg;
      pz_q   <= pz;
      qneg_q <= qneg;
      rn_q   <= rn;
      rd_q   <= rd;
      ma_q   <= ma;
      mb_q   <= mb;
      mc_q   <= mc;
      md_q   <= md;
    end
  end

  // Both comparisons use the fractions as they stood before this edge.
  always_comb begin
    stb_d = sta_q;
    priority if (!sta_q.ok) begin
      stb_d.ok = 1'b0;
    end else if (pz_q) begin
      stb_d.ok = !qneg_q;
    end else if (pneg_q) begin
      if (ma_q > mb_q) begin
        stb_d.ok = 1'b0;
      end else if (mc_q > md_q) begin
        stb_d.n0 = rn_q;
        stb_d.d0 = rd_q;
      end
    end else begin
      if (mc_q < md_q) begin
        stb_d.ok = 1'b0;
      end else if (ma_q < mb_q) begin
        stb_d.n1 = rn_q;
        stb_d.d1 = rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldb_q <= 1'b0;
    end else if (en_i) begin
      vldb_q <= vlda_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stb_q <= stb_d;
    end
  end

  assign valid_o = vldb_q;
  assign st_o    = stb_q;

endmodule

@@ sv/lbc_place.sv @@
// Forms the rounding dividend and divisor for each of the four clipped coordinates.
module lbc_place (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  lbc_pkg::clip_st_t               st_i,
  output lbc_pkg::lane_sb_t               sb_o,
  output logic signed [lbc_pkg::NW-1:0]   num_o [lbc_pkg::LANES],
  output logic signed [lbc_pkg::NW-1:0]   den_o [lbc_pkg::LANES],
  output logic [lbc_pkg::OW-1:0]          hi_o  [lbc_pkg::LANES]
);
  import lbc_pkg::*;

  logic signed [CW-1:0] a   [LANES];
  logic signed [DW-1:0] dl  [LANES];
  logic signed [QW-1:0] n   [LANES];
  logic signed [DW-1:0] d   [LANES];
  logic [OW-1:0]        hi  [LANES];

  lane_sb_t             sb1_q, sb2_q;
  logic signed [NW-1:0] pa_q [LANES];
  logic signed [NW-1:0] pb_q [LANES];
  logic signed [DW-1:0] d_q  [LANES];
  logic [OW-1:0]        hi1_q [LANES];
  logic signed [NW-1:0] num_q [LANES];
  logic signed [NW-1:0] den_q [LANES];
  logic [OW-1:0]        hi2_q [LANES];

  // Lanes: start x, start y from t0; end x, end y from t1.
  always_comb begin
    a[0] = st_i.ax; dl[0] = st_i.dx; n[0] = st_i.n0; d[0] = st_i.d0; hi[0] = st_i.xmax;
    a[1] = st_i.ay; dl[1] = st_i.dy; n[1] = st_i.n0; d[1] = st_i.d0; hi[1] = st_i.ymax;
    a[2] = st_i.ax; dl[2] = st_i.dx; n[2] = st_i.n1; d[2] = st_i.d1; hi[2] = st_i.xmax;
    a[3] = st_i.ay; dl[3] = st_i.dy; n[3] = st_i.n1; d[3] = st_i.d1; hi[3] = st_i.ymax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb1_q <= '0;
      sb2_q <= '0;
    end else if (en_i) begin
      sb1_q <= '{valid: valid_i, ok: st_i.ok};
      sb2_q <= sb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        pa_q[l]  <= a[l] * d[l];
        pb_q[l]  <= n[l] * dl[l];
        d_q[l]   <= d[l];
        hi1_q[l] <= hi[l];
        // floor((2*num + d) / (2*d)) rounds num/d half up.
        num_q[l] <= ((pa_q[l] + pb_q[l]) <<< 1) + NW'(d_q[l]);
        den_q[l] <= NW'(d_q[l]) <<< 1;
        hi2_q[l] <= hi1_q[l];
      end
    end
  end

  assign sb_o  = sb2_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign hi_o  = hi2_q;

endmodule

@@ sv/lbc_div.sv @@
// Pipelined restoring divider with clamping, one quotient bit per stage, four lanes.
module lbc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  lbc_pkg::lane_sb_t               sb_i,
  input  logic signed [lbc_pkg::NW-1:0]   num_i [lbc_pkg::LANES],
  input  logic signed [lbc_pkg::NW-1:0]   den_i [lbc_pkg::LANES],
  input  logic [lbc_pkg::OW-1:0]          hi_i  [lbc_pkg::LANES],
  output logic                            valid_o,
  output logic                            accepted_o,
  output logic [lbc_pkg::OW-1:0]          coord_o [lbc_pkg::LANES]
);
  import lbc_pkg::*;

  lane_sb_t             sb_q  [QB+1];
  logic signed [NW-1:0] rem_q [QB+1][LANES];
  logic signed [NW-1:0] den_q [QB+1][LANES];
  logic [OW-1:0]        quo_q [QB+1][LANES];
  logic [OW-1:0]        hi_q  [QB+1][LANES];
  logic [LANES-1:0]     neg_q [QB+1];
  logic [LANES-1:0]     sat_q [QB+1];

  lane_sb_t             sbf_q;
  logic [OW-1:0]        coord_q [LANES];

  // A negative dividend floors below zero; one at or above the divisor
  // times 2^QB lies beyond any raster edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q[0] <= '0;
    end else if (en_i) begin
      sb_q[0] <= sb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l]  <= num_i[l];
        den_q[0][l]  <= den_i[l];
        quo_q[0][l]  <= '0;
        hi_q[0][l]   <= hi_i[l];
        neg_q[0][l]  <= num_i[l][NW-1];
        sat_q[0][l]  <= !num_i[l][NW-1] && (num_i[l] >= (den_i[l] <<< QB));
      end
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int Sh = QB - 1 - k;
    logic signed [NW-1:0] trial [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = rem_q[k][l] - (den_q[k][l] <<< Sh);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_q[k+1] <= '0;
      end else if (en_i) begin
        sb_q[k+1] <= sb_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          if (!trial[l][NW-1]) begin
            rem_q[k+1][l] <= trial[l];
            quo_q[k+1][l] <= quo_q[k][l] | (OW'(1) << Sh);
          end else begin
            rem_q[k+1][l] <= rem_q[k][l];
            quo_q[k+1][l] <= quo_q[k][l];
          end
          den_q[k+1][l] <= den_q[k][l];
          hi_q[k+1][l]  <= hi_q[k][l];
        end
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbf_q <= '0;
    end else if (en_i) begin
      sbf_q <= sb_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        priority if (!sb_q[QB].ok || neg_q[QB][l]) begin
          coord_q[l] <= '0;
        end else if (sat_q[QB][l] || (quo_q[QB][l] > hi_q[QB][l])) begin
          coord_q[l] <= hi_q[QB][l];
        end else begin
          coord_q[l] <= quo_q[QB][l];
        end
      end
    end
  end

  assign valid_o    = sbf_q.valid;
  assign accepted_o = sbf_q.ok;
  assign coord_o    = coord_q;

endmodule

@@ sv/line_segment_pixel_clip.sv @@
// Top level of the line segment clipper: raster registers, input stage and pipeline.
//
// Clips one line segment per transaction to the raster of columns
// 0..width-1 and rows 0..height-1 by Liang-Barsky edge tests.
// Input channel: in_valid_i/in_ready_o with the two endpoints.
// Output channel: out_valid_o/out_ready_i with the accept flag and the
// clipped endpoints, rounded half up and clamped; all zero when rejected.
// Configuration channel: cfg_valid_i/cfg_ready_o, index 0 writes the raster
// width and index 1 the raster height; it is always ready, and the user must
// write it only while the pipeline is empty (the block does not enforce it).
// Sizes above 4096 count as 4096. Throughput is one segment per cycle while
// the receiver does not stall. The pipeline holds an input register, then per edge
// test a product and a compare register, then coordinate product and sum registers,
// and the divider: an entry register, one per quotient bit, and an output one.
// Reset empties the pipeline and sets both raster sizes to 1024.
// When the receiver stalls the whole pipeline holds and in_ready_o falls
// until the waiting result is taken.
module line_segment_pixel_clip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [lbc_pkg::CW-1:0] start_x_i,
  input  logic signed [lbc_pkg::CW-1:0] start_y_i,
  input  logic signed [lbc_pkg::CW-1:0] end_x_i,
  input  logic signed [lbc_pkg::CW-1:0] end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic [lbc_pkg::OW-1:0]        clipped_start_x_o,
  output logic [lbc_pkg::OW-1:0]        clipped_start_y_o,
  output logic [lbc_pkg::OW-1:0]        clipped_end_x_o,
  output logic [lbc_pkg::OW-1:0]        clipped_end_y_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [lbc_pkg::RW-1:0]        cfg_data_i
);
  import lbc_pkg::*;

  logic            en;
  logic [RW-1:0]   width_q, height_q;
  logic [RW-1:0]   wsat, hsat;
  clip_st_t        in_st_d, in_st_q;
  logic            in_vld_q;

  logic            e_vld [LANES+1];
  clip_st_t        e_st  [LANES+1];

  lane_sb_t             p_sb;
  logic signed [NW-1:0] p_num [LANES];
  logic signed [NW-1:0] p_den [LANES];
  logic [OW-1:0]        p_hi  [LANES];
  logic [OW-1:0]        coord [LANES];

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RW'(RESET_DIM);
      height_q <= RW'(RESET_DIM);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    wsat = (width_q > RW'(MAX_DIM)) ? RW'(MAX_DIM) : width_q;
    hsat = (height_q > RW'(MAX_DIM)) ? RW'(MAX_DIM) : height_q;
    in_st_d.ok   = (wsat != '0) && (hsat != '0);
    in_st_d.ax   = start_x_i;
    in_st_d.ay   = start_y_i;
    in_st_d.dx   = DW'(end_x_i) - DW'(start_x_i);
    in_st_d.dy   = DW'(end_y_i) - DW'(start_y_i);
    in_st_d.xmax = OW'(wsat - RW'(1));
    in_st_d.ymax = OW'(hsat - RW'(1));
    in_st_d.n0   = '0;
    in_st_d.d0   = DW'(1);
    in_st_d.n1   = QW'(1);
    in_st_d.d1   = DW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_st_q <= in_st_d;
    end
  end

  assign e_vld[0] = in_vld_q;
  assign e_st[0]  = in_st_q;

  // Left, right, top and bottom edges in that order.
  for (genvar i = 0; i < LANES; i++) begin : g_edge
    lbc_edge u_edge (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (e_vld[i]),
      .st_i    (e_st[i]),
      .p_i     (edge_p(e_st[i], edge_e'(i))),
      .q_i     (edge_q(e_st[i], edge_e'(i))),
      .valid_o (e_vld[i+1]),
      .st_o    (e_st[i+1])
    );
  end

  lbc_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_vld[LANES]),
    .st_i    (e_st[LANES]),
    .sb_o    (p_sb),
    .num_o   (p_num),
    .den_o   (p_den),
    .hi_o    (p_hi)
  );

  lbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .sb_i       (p_sb),
    .num_i      (p_num),
    .den_i      (p_den),
    .hi_i       (p_hi),
    .valid_o    (out_valid_o),
    .accepted_o (accepted_o),
    .coord_o    (coord)
  );

  assign clipped_start_x_o = coord[0];
  assign clipped_start_y_o = coord[1];
  assign clipped_end_x_o   = coord[2];
  assign clipped_end_y_o   = coord[3];

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the line segment clipper, with a scoreboard class.
`timescale 1ns / 100ps

module tb_top;
  import lbc_pkg::*;

  localparam int LATENCY = 25;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic signed [CW-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic out_valid_o, out_ready_i, accepted_o;
  logic [OW-1:0] clipped_start_x_o, clipped_start_y_o, clipped_end_x_o, clipped_end_y_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [RW-1:0] cfg_data_i;

  line_segment_pixel_clip dut (.*);

  typedef struct {
    bit acc;
    bit [OW-1:0] sx, sy, ex, ey;
  } clip_res_t;

  int  error_count = 0;
  longint cycle_count = 0;
  bit  stall_hold = 0;
  bit  no_idle = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  class clip_scoreboard;
    bit [RW-1:0] width_reg = RW'(RESET_DIM);
    bit [RW-1:0] height_reg = RW'(RESET_DIM);
    clip_res_t pending[$];

    function longint floor_div(longint a, longint b);
      longint q = a / b;
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
    endfunction

    // Returns 0 when the segment lies wholly outside this edge.
    function bit narrow(longint p, longint q, ref longint n0, d0, n1, d1);
      longint rn, rd;
      if (p == 0) return q >= 0;
      if (p < 0) begin
        rn = -q; rd = -p;
        if (rn * d1 > n1 * rd) return 0;
        if (rn * d0 > n0 * rd) begin n0 = rn; d0 = rd; end
      end else begin
        rn = q; rd = p;
        if (rn * d0 < n0 * rd) return 0;
        if (rn * d1 < n1 * rd) begin n1 = rn; d1 = rd; end
      end
      return 1;
    endfunction

    function bit [OW-1:0] place(longint a, longint dl, longint n, longint d, longint hi);
      longint v;
      v = floor_div(2 * (a * d + n * dl) + d, 2 * d);
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return v[OW-1:0];
    endfunction

    function void note_segment(longint ax, longint ay, longint bx, longint by);
      clip_res_t r;
      longint w, h, dx, dy, n0, d0, n1, d1;
      bit ok;
      r = '{0, 0, 0, 0, 0};
      w = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
      h = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
      dx = bx - ax; dy = by - ay;
      n0 = 0; d0 = 1; n1 = 1; d1 = 1;
      if (w > 0 && h > 0) begin
        ok = narrow(-dx, ax, n0, d0, n1, d1);
        if (ok) ok = narrow(dx, w - 1 - ax, n0, d0, n1, d1);
        if (ok) ok = narrow(-dy, ay, n0, d0, n1, d1);
        if (ok) ok = narrow(dy, h - 1 - ay, n0, d0, n1, d1);
        if (ok) begin
          r.acc = 1;
          r.sx = place(ax, dx, n0, d0, w - 1);
          r.sy = place(ay, dy, n0, d0, h - 1);
          r.ex = place(ax, dx, n1, d1, w - 1);
          r.ey = place(ay, dy, n1, d1, h - 1);
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(clip_res_t got);
      clip_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, accepted", got.acc, 0);
        return;
      end
      want = pending.pop_front();
      if (got.acc != want.acc) report_mismatch("accepted", got.acc, want.acc);
      if (got.sx != want.sx) report_mismatch("clipped_start_x", got.sx, want.sx);
      if (got.sy != want.sy) report_mismatch("clipped_start_y", got.sy, want.sy);
      if (got.ex != want.ex) report_mismatch("clipped_end_x", got.ex, want.ex);
      if (got.ey != want.ey) report_mismatch("clipped_end_y", got.ey, want.ey);
    endtask
  endclass

  clip_scoreboard sb = new();

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("** line_segment_pixel_clip: FAILED **");
      $finish;
    end
  end

  // Output side: sample at the rising edge, change ready at the falling edge.
  always @(posedge clk_i) begin
    clip_res_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.acc = accepted_o; r.sx = clipped_start_x_o; r.sy = clipped_start_y_o;
      r.ex = clipped_end_x_o; r.ey = clipped_end_y_o;
      sb.check_result(r);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || stall_hold) out_ready_i <= 0;
    else out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
  end

  // Valid stays high from one transaction to the next unless the sender idles.
  task automatic send_segment(logic signed [CW-1:0] ax, ay, bx, by);
    if (!no_idle)
      while ($urandom_range(99) < 36) begin
        in_valid_i <= 0;
        @(negedge clk_i);
      end
    in_valid_i <= 1;
    start_x_i <= ax; start_y_i <= ay; end_x_i <= bx; end_y_i <= by;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_segment(ax, ay, bx, by);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_raster(logic [1:0] idx, logic [RW-1:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDX_WIDTH) sb.width_reg = val;
    else sb.height_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int w);
    case ($urandom_range(9))
      0:       return CW'($urandom());
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2:       return CW'(int'($urandom_range(3)) - 2);
      3:       return CW'(w + int'($urandom_range(4)) - 2);
      default: return CW'(int'($urandom_range(w + w / 2 + 8)) - w / 4 - 4);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic signed [CW-1:0] ax, ay, bx, by;
    int w, h;
    w = (sb.width_reg > MAX_DIM) ? MAX_DIM : sb.width_reg;
    h = (sb.height_reg > MAX_DIM) ? MAX_DIM : sb.height_reg;
    repeat (count) begin
      ax = rand_coord(w); ay = rand_coord(h);
      bx = rand_coord(w); by = rand_coord(h);
      case ($urandom_range(7))
        0: bx = ax;
        1: by = ay;
        2: begin bx = ax; by = ay; end
        default: ;
      endcase
      send_segment(ax, ay, bx, by);
    end
  endtask

  initial begin
    in_valid_i = 0; start_x_i = 0; start_y_i = 0; end_x_i = 0; end_y_i = 0;
    cfg_valid_i = 0; cfg_index_i = CFG_IDX_WIDTH; cfg_data_i = 0;
    out_ready_i = 0;
    rst_ni = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: corners, extremes, parallel edges, degenerate points, half-way rounding.
    send_segment(0, 0, 1023, 1023);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-5, 10, -5, 500);
    send_segment(2000, 10, 2000, 500);
    send_segment(10, -3, 900, -3);
    send_segment(10, 1024, 900, 1024);
    send_segment(100, 100, 100, 100);
    send_segment(-1, 100, -1, 100);
    send_segment(-1, -1, 2, 0);
    send_segment(-3, 1, 3, 2);
    send_segment(1023, 1023, 1024, 1024);
    send_segment(-100, 512, 2000, 512);
    send_segment(-1, -1, -1, -1);
    drain_pipeline();

    write_raster(CFG_IDX_WIDTH, 0);
    send_segment(0, 0, 5, 5);
    drain_pipeline();
    write_raster(CFG_IDX_WIDTH, 8191);
    write_raster(CFG_IDX_HEIGHT, 0);
    send_segment(0, 0, 5, 5);
    drain_pipeline();
    write_raster(CFG_IDX_HEIGHT, 4096);
    send_segment(-32768, 4095, 32767, 4096);
    send_segment(4095, 4095, 4095, 4095);
    drain_pipeline();

    write_raster(CFG_IDX_WIDTH, 1);
    write_raster(CFG_IDX_HEIGHT, 1);
    send_segment(0, 0, 0, 0);
    send_segment(-1, -1, 1, 1);
    drain_pipeline();

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    write_raster(CFG_IDX_WIDTH, 640);
    write_raster(CFG_IDX_HEIGHT, 480);
    fork
      begin
        stall_hold = 1;
        repeat (120) @(negedge clk_i);
        stall_hold = 0;
      end
      random_phase(80);
    join
    drain_pipeline();

    no_idle = 1;
    random_phase(300);
    drain_pipeline();
    no_idle = 0;

    write_raster(CFG_IDX_WIDTH, 4096);
    write_raster(CFG_IDX_HEIGHT, 4096);
    random_phase(400);
    drain_pipeline();
    write_raster(CFG_IDX_WIDTH, 2);
    write_raster(CFG_IDX_HEIGHT, 3);
    random_phase(200);
    drain_pipeline();
    write_raster(CFG_IDX_WIDTH, RW'($urandom_range(8191)));
    write_raster(CFG_IDX_HEIGHT, RW'($urandom_range(4096, 8191)));
    random_phase(300);
    drain_pipeline();
    write_raster(CFG_IDX_WIDTH, RW'($urandom_range(1, 4096)));
    write_raster(CFG_IDX_HEIGHT, RW'($urandom_range(1, 4096)));
    random_phase(550);
    drain_pipeline();

    if (error_count == 0) $display("** line_segment_pixel_clip: PASSED **");
    else $display("** line_segment_pixel_clip: FAILED **");
    $finish;
  end
endmodule

@@ files.f @@
sv/lbc_pkg.sv
sv/lbc_edge.sv
sv/lbc_place.sv
sv/lbc_div.sv
sv/line_segment_pixel_clip.sv
test/tb_top.sv
